### rtl/xrrg_pkg.sv
// Package for the xoshiro range random generator: stream widths, generator
// constants, status codes and the controller/datapath command and status types.
// No dependencies.
package xrrg_pkg;

	localparam int IN_TDATA_W  = 160;	// low_bound, high_bound, excluded
	localparam int OUT_TDATA_W = 64;	// value

	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = 6;

	// splitmix64 constants
	localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2     = 64'h94d049bb133111eb;
	localparam int          MIX_SH_A   = 30;
	localparam int          MIX_SH_B   = 27;
	localparam int          MIX_SH_C   = 31;

	// xoshiro256++ constants
	localparam int XO_ROT_RES = 23;
	localparam int XO_SHL_T   = 17;
	localparam int XO_ROT_S3  = 45;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_INVERTED = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;

	localparam logic OP_PLAIN   = 1'b0;
	localparam logic OP_EXCLUDE = 1'b1;

	typedef struct packed {
		logic       load_in;	// capture the request
		logic       setup;		// register lower bound and span
		logic       seed_init;	// counter from seed register
		logic       seed_add;	// advance counter, first xor-shift
		logic       mul_ll;		// partial product low x low
		logic       mul_hl;		// partial product high x low
		logic       mul_lh;		// partial product low x high
		logic       xshift;		// xor-shift of the product
		logic       phase;		// 0: first multiply, 1: second multiply
		logic [1:0] word_idx;	// state word being seeded
		logic       draw_sum;	// s0 + s3
		logic       draw_step;	// output word and state update
		logic       div_step;	// one remainder bit
		logic       add_lo;		// add lower bound
		logic       out_load;	// load the output register
		logic [1:0] status;		// status for the output register
	} xrrg_cmd_t;

	typedef struct packed {
		logic op;
		logic range_inv;	// 32-bit low above high
		logic single_ex;	// single value, and it is the excluded one
		logic span_zero;	// 64-bit span wrapped to zero
	} xrrg_stat_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int s);
		return (x << s) | (x >> (64 - s));
	endfunction

endpackage

### rtl/xrrg_ctrl.sv
// Controller of the xoshiro range random generator: sequences request checks,
// seeding, the draw, the remainder loop and the output load. Uses xrrg_pkg.
module xrrg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                cfg_wr_en,
	input  xrrg_pkg::xrrg_stat_t stat,
	output xrrg_pkg::xrrg_cmd_t  cmd
);
	import xrrg_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CHECK  = 4'd1;
	localparam logic [3:0] ST_SADD   = 4'd2;
	localparam logic [3:0] ST_MUL0   = 4'd3;
	localparam logic [3:0] ST_MUL1   = 4'd4;
	localparam logic [3:0] ST_MUL2   = 4'd5;
	localparam logic [3:0] ST_XSHIFT = 4'd6;
	localparam logic [3:0] ST_DRAW1  = 4'd7;
	localparam logic [3:0] ST_DRAW2  = 4'd8;
	localparam logic [3:0] ST_DIV    = 4'd9;
	localparam logic [3:0] ST_ADD    = 4'd10;
	localparam logic [3:0] ST_OUT    = 4'd11;

	logic [3:0]           state_q, state_d;
	logic                 seeded_q, seeded_d;
	logic                 phase_q, phase_d;
	logic [1:0]           word_q, word_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]           status_q, status_d;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		seeded_d = seeded_q;
		phase_d  = phase_q;
		word_d   = word_q;
		cnt_d    = cnt_q;
		status_d = status_q;
		cmd      = '0;
		cmd.phase    = phase_q;
		cmd.word_idx = word_q;
		cmd.status   = status_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.setup = 1'b1;
				if (stat.op == OP_EXCLUDE && stat.range_inv) begin
					status_d = STATUS_INVERTED;
					state_d  = ST_OUT;
				end else if (stat.op == OP_EXCLUDE && stat.single_ex) begin
					status_d = STATUS_EMPTY;
					state_d  = ST_OUT;
				end else begin
					status_d = STATUS_OK;
					if (!seeded_q) begin
						cmd.seed_init = 1'b1;
						phase_d       = 1'b0;
						word_d        = 2'd0;
						state_d       = ST_SADD;
					end else begin
						state_d = ST_DRAW1;
					end
				end
			end
			ST_SADD: begin
				cmd.seed_add = 1'b1;
				state_d      = ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul_ll = 1'b1;
				state_d    = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_hl = 1'b1;
				state_d    = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_lh = 1'b1;
				state_d    = ST_XSHIFT;
			end
			ST_XSHIFT: begin
				cmd.xshift = 1'b1;
				if (!phase_q) begin
					phase_d = 1'b1;
					state_d = ST_MUL0;
				end else begin
					phase_d = 1'b0;
					word_d  = word_q + 2'd1;
					if (word_q == 2'd3) begin
						seeded_d = 1'b1;
						state_d  = ST_DRAW1;
					end else begin
						state_d = ST_SADD;
					end
				end
			end
			ST_DRAW1: begin
				cmd.draw_sum = 1'b1;
				state_d      = ST_DRAW2;
			end
			ST_DRAW2: begin
				cmd.draw_step = 1'b1;
				cnt_d         = '0;
				state_d       = stat.span_zero ? ST_ADD : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_lo = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cfg_wr_en) begin
			seeded_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			phase_q     <= 1'b0;
			word_q      <= 2'd0;
			cnt_q       <= '0;
			status_q    <= STATUS_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			seeded_q <= seeded_d;
			phase_q  <= phase_d;
			word_q   <= word_d;
			cnt_q    <= cnt_d;
			status_q <= status_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/xrrg_datapath.sv
// Datapath of the xoshiro range random generator: request registers, seed
// expansion with a shared 32x32 multiplier, generator state, bit-serial
// remainder and the output register. Uses xrrg_pkg.
module xrrg_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  xrrg_pkg::xrrg_cmd_t                   cmd,
	output xrrg_pkg::xrrg_stat_t                  stat,
	input  logic                                 cfg_wr_en,
	input  logic [63:0]                          cfg_wr_data,
	input  logic                                 in_op,
	input  logic [xrrg_pkg::IN_TDATA_W-1:0]      in_data,
	output logic [xrrg_pkg::OUT_TDATA_W-1:0]     out_data,
	output logic [1:0]                           out_status
);
	import xrrg_pkg::*;

	logic               op_q;
	logic [63:0]        lo_in_q, hi_in_q;
	logic signed [31:0] ex_q;
	logic [63:0]        seed_q;
	logic [63:0]        lo_q, span_q;
	logic               adj_q;
	logic [63:0]        counter_q, z_q, prod_q, sum_q, rem_q, dvd_q;
	logic [63:0]        gs_q [4];
	logic [63:0]        val_q;
	logic [1:0]         stat_q;

	logic signed [31:0] lo32, hi32;
	logic               ex_out;
	logic [63:0]        lo_eff, hi_eff, span_next;
	logic [63:0]        mix_c, mix_t, xs_out;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p;
	logic [63:0]        draw_r, tmp_t, ns0, ns1, ns2, ns3;
	logic [64:0]        trial, trial_sub;
	logic [31:0]        fin32;
	logic [63:0]        fin_val;

	assign lo32   = $signed(lo_in_q[31:0]);
	assign hi32   = $signed(hi_in_q[31:0]);
	assign ex_out = (ex_q < lo32) || (ex_q > hi32);
	assign lo_eff = (op_q == OP_EXCLUDE) ? {{32{lo32[31]}}, lo32} : lo_in_q;
	assign hi_eff = (op_q == OP_EXCLUDE) ? {{32{hi32[31]}}, hi32} : hi_in_q;
	// the excluded value shortens the draw range by one
	assign span_next = hi_eff - lo_eff + {63'd0, !(op_q == OP_EXCLUDE && !ex_out)};

	assign stat.op        = op_q;
	assign stat.range_inv = lo32 > hi32;
	assign stat.single_ex = (lo32 == hi32) && !ex_out;
	assign stat.span_zero = (span_q == 64'd0);

	// seed expansion
	assign mix_c  = cmd.phase ? MIX_C2 : MIX_C1;
	assign mix_t  = counter_q + MIX_GOLDEN;
	assign mul_a  = cmd.mul_hl ? z_q[63:32] : z_q[31:0];
	assign mul_b  = cmd.mul_lh ? mix_c[63:32] : mix_c[31:0];
	assign mul_p  = {32'd0, mul_a} * {32'd0, mul_b};
	assign xs_out = cmd.phase ? (prod_q ^ (prod_q >> MIX_SH_C))
	                          : (prod_q ^ (prod_q >> MIX_SH_B));

	// generator step
	assign draw_r = rotl64(sum_q, XO_ROT_RES) + gs_q[0];
	assign tmp_t  = gs_q[1] << XO_SHL_T;
	assign ns2    = gs_q[2] ^ gs_q[0];
	assign ns3    = gs_q[3] ^ gs_q[1];
	assign ns1    = gs_q[1] ^ ns2;
	assign ns0    = gs_q[0] ^ ns3;

	// restoring remainder, one dividend bit per step
	assign trial     = {rem_q, dvd_q[63]};
	assign trial_sub = trial - {1'b0, span_q};

	assign fin32   = rem_q[31:0] +
	                 {31'd0, (adj_q && ($signed(rem_q[31:0]) >= ex_q))};
	assign fin_val = (op_q == OP_EXCLUDE) ? {{32{fin32[31]}}, fin32} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= in_op;
			lo_in_q <= in_data[63:0];
			hi_in_q <= in_data[127:64];
			ex_q    <= $signed(in_data[159:128]);
		end
		if (cmd.setup) begin
			lo_q   <= lo_eff;
			span_q <= span_next;
			adj_q  <= (op_q == OP_EXCLUDE) && !ex_out;
		end
		if (cmd.seed_init) begin
			counter_q <= seed_q;
		end else if (cmd.seed_add) begin
			counter_q <= mix_t;
		end
		if (cmd.seed_add) begin
			z_q <= mix_t ^ (mix_t >> MIX_SH_A);
		end else if (cmd.xshift && !cmd.phase) begin
			z_q <= xs_out;
		end
		if (cmd.mul_ll) begin
			prod_q <= mul_p;
		end else if (cmd.mul_hl || cmd.mul_lh) begin
			prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
		end
		if (cmd.xshift && cmd.phase) begin
			gs_q[cmd.word_idx] <= xs_out;
		end else if (cmd.draw_step) begin
			gs_q[0] <= ns0;
			gs_q[1] <= ns1;
			gs_q[2] <= ns2 ^ tmp_t;
			gs_q[3] <= rotl64(ns3, XO_ROT_S3);
		end
		if (cmd.draw_sum) begin
			sum_q <= gs_q[0] + gs_q[3];
		end
		if (cmd.draw_step) begin
			rem_q <= stat.span_zero ? draw_r : 64'd0;
			dvd_q <= draw_r;
		end else if (cmd.div_step) begin
			rem_q <= trial_sub[64] ? trial[63:0] : trial_sub[63:0];
			dvd_q <= {dvd_q[62:0], 1'b0};
		end else if (cmd.add_lo) begin
			rem_q <= rem_q + lo_q;
		end
		if (cmd.out_load) begin
			val_q  <= (cmd.status == STATUS_OK) ? fin_val : 64'd0;
			stat_q <= cmd.status;
		end
	end

	assign out_data   = val_q;
	assign out_status = stat_q;

endmodule

### rtl/xoshiro_range_random_generator.sv
// Top level of the xoshiro range random generator: stream ports, seed register
// port, controller and datapath. Uses xrrg_pkg, xrrg_ctrl and xrrg_datapath.
//
//  Channel   Direction  Handshake          Payload
//  --------  ---------  -----------------  -----------------------------------------
//  s_*       in         s_tvalid/s_tready  tuser: op; tdata: low, high, excluded
//  m_*       out        m_tvalid/m_tready  tuser: status; tdata: value
//  cfg_*     in         cfg_wr_en          cfg_wr_data: seed_value
//
// A drawing request passes a check state, two draw states, the bit-serial
// remainder loop over all 64 dividend bits, an add state and an output state.
// A zero span skips the remainder loop. A request that ends in an error
// status goes from the check state straight to the output state, with no draw.
// The first draw after reset or after a seed write first expands the seed:
// four words of nine steps each around one shared 32x32 multiplier.
// One request is in work at a time; s_tready is high only while idle, and a
// finished transaction waits in the output register without blocking s_*.
// Reset clears the control state and the seed register to zero.
module xoshiro_range_random_generator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// low_bound [63:0], high_bound [127:64], excluded [159:128]
	input  logic [xrrg_pkg::IN_TDATA_W-1:0]      s_tdata,
	// op [0]
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// value [63:0]
	output logic [xrrg_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// status [1:0]
	output logic [1:0]                           m_tuser,
	input  logic                                 cfg_wr_en,
	input  logic [63:0]                          cfg_wr_data
);
	import xrrg_pkg::*;

	xrrg_cmd_t  cmd;
	xrrg_stat_t stat;

	// controller: sequencing, handshakes, seeded flag
	xrrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cfg_wr_en (cfg_wr_en),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: registers, seed expansion, generator, remainder, output
	xrrg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_op       (s_tuser),
		.in_data     (s_tdata),
		.out_data    (m_tdata),
		.out_status  (m_tuser)
	);

	// hold off new transactions while a request is in work
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a request is in work");

	// an error status always carries a zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata == 64'd0))
		else $error("error status with nonzero value");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_INVERTED ||
		              m_tuser == STATUS_EMPTY))
		else $error("undefined status code");

	// the output register only loads when it is free
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output overwritten before it was taken");

endmodule

### bench/xoshiro_range_random_generator_tb.sv
// Self-checking bench for the xoshiro range random generator: streams range
// requests, reseeds between phases and checks every result against a predictor.
// Depends on xrrg_pkg and the xoshiro_range_random_generator top level.
`timescale 1ns / 100ps

module xoshiro_range_random_generator_tb;
	import xrrg_pkg::*;

	// Generator constants for the predictor
	localparam logic [63:0] GAMMA      = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;
	localparam logic [63:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] NEG_MIN32  = 64'hffff_ffff_8000_0000;
	localparam logic [63:0] POS_MAX32  = 64'h0000_0000_7fff_ffff;
	localparam logic [31:0] EX_MIN     = 32'h8000_0000;
	localparam logic [31:0] EX_MAX     = 32'h7fff_ffff;
	localparam longint      INT32_MAX  = 64'sd2147483647;
	localparam int          LONG_HOLD  = 600;
	localparam int          PHASE_ITEMS = 150;
	localparam int          NUM_PHASES  = 7;

	typedef enum logic {PACE_FULL, PACE_RANDOM} pace_t;

	typedef struct packed {
		logic        op;
		logic [63:0] low_bound;
		logic [63:0] high_bound;
		logic [31:0] excluded;
	} range_request_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
	} range_result_t;

	logic                   clk;
	logic                   arst_n      = 1'b0;
	logic                   s_tvalid    = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata     = '0;
	logic                   s_tuser     = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready    = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   cfg_wr_en   = 1'b0;
	logic [63:0]            cfg_wr_data = '0;

	// Predictor copy of the generator: seed register, state words, seeding flag
	logic [63:0] seed_reg = '0;
	logic [63:0] gen_s [4] = '{default: '0};
	logic        seeded   = 1'b0;
	logic [63:0] mix_ctr  = '0;

	range_request_t request_queue [$];
	range_result_t  awaited_results [$];
	range_request_t cur_req;

	pace_t tx_pace = PACE_FULL;
	pace_t rx_pace = PACE_FULL;
	int    tx_gap  = 0;
	int    rx_hold = 0;
	int    holds_asked  = 0;
	int    holds_served = 0;

	int errors      = 0;
	int n_plain     = 0;
	int n_exclude   = 0;
	int n_inverted  = 0;
	int n_empty     = 0;
	int n_seeds     = 0;

	xoshiro_range_random_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// One splitmix64 output; advances the seeding counter.
	function automatic logic [63:0] splitmix_step();
		logic [63:0] z;
		mix_ctr = mix_ctr + GAMMA;
		z = mix_ctr;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	// One xoshiro256++ output. Seeds lazily on the first draw after reset or
	// a seed write, so error requests never trigger seeding.
	function automatic logic [63:0] xoshiro_draw();
		logic [63:0] sum;
		logic [63:0] res;
		logic [63:0] t;
		if (!seeded) begin
			mix_ctr = seed_reg;
			for (int i = 0; i < 4; i++)
				gen_s[i] = splitmix_step();
			seeded = 1'b1;
		end
		sum = gen_s[0] + gen_s[3];
		res = {sum[40:0], sum[63:41]} + gen_s[0];
		t = gen_s[1] << 17;
		gen_s[2] ^= gen_s[0];
		gen_s[3] ^= gen_s[1];
		gen_s[1] ^= gen_s[2];
		gen_s[0] ^= gen_s[3];
		gen_s[2] ^= t;
		gen_s[3] = {gen_s[3][18:0], gen_s[3][63:19]};
		return res;
	endfunction

	// Reduce one draw into lo..hi with wrapping 64-bit arithmetic; a span
	// that wraps to zero means the whole 64-bit space.
	function automatic logic [63:0] draw_in_range(input logic [63:0] lo, input logic [63:0] hi);
		logic [63:0] r;
		logic [63:0] span;
		r = xoshiro_draw();
		span = hi - lo + 64'd1;
		if (span == '0)
			return r + lo;
		return r % span + lo;
	endfunction

	function automatic range_result_t predict_range_draw(input range_request_t rq);
		range_result_t res;
		logic signed [63:0] lo_s;
		logic signed [63:0] hi_s;
		logic signed [63:0] ex_s;
		logic signed [63:0] v;
		logic [63:0] raw;
		res.value = '0;
		res.status = STATUS_OK;
		if (rq.op == OP_PLAIN) begin
			res.value = draw_in_range(rq.low_bound, rq.high_bound);
		end else begin
			// only the low words count, read as signed 32-bit values
			lo_s = $signed(rq.low_bound[31:0]);
			hi_s = $signed(rq.high_bound[31:0]);
			ex_s = $signed(rq.excluded);
			if (lo_s > hi_s) begin
				res.status = STATUS_INVERTED;
			end else if (ex_s < lo_s || ex_s > hi_s) begin
				raw = draw_in_range(lo_s, hi_s);
				v = $signed(raw[31:0]);
				res.value = v;
			end else if (lo_s == hi_s) begin
				res.status = STATUS_EMPTY;
			end else begin
				// draw one short and step over the excluded value
				raw = draw_in_range(lo_s, hi_s - 64'sd1);
				v = $signed(raw[31:0]);
				if (v >= ex_s)
					v = v + 64'sd1;
				res.value = v;
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly short gaps, some medium, a few long ones; none at full pace.
	function automatic int pick_gap(input pace_t pace);
		int r;
		if (pace == PACE_FULL)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	// 32-bit bound placed in a 64-bit field; now and then with junk upper bits,
	// which the exclusion op must ignore.
	function automatic logic [63:0] bound_bits(input longint v);
		if ($urandom_range(0, 3) == 0)
			return {$urandom(), v[31:0]};
		return {{32{v[31]}}, v[31:0]};
	endfunction

	function automatic range_request_t random_request();
		range_request_t rq;
		longint a;
		longint b;
		longint ex;
		longint w;
		rq.excluded = $urandom();
		if ($urandom_range(0, 99) < 40) begin
			rq.op = OP_PLAIN;
			rq.low_bound = rand64();
			case ($urandom_range(0, 3))
				0: rq.high_bound = rand64();
				1: rq.high_bound = rq.low_bound + $urandom_range(0, 1000);
				// full or nearly full span, including the wrap to zero
				2: rq.high_bound = rq.low_bound - 64'd1 - $urandom_range(0, 3);
				default: begin
					if ($urandom_range(0, 1) != 0)
						rq.low_bound = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
					rq.high_bound = rq.low_bound + (rand64() >> $urandom_range(1, 40));
				end
			endcase
		end else begin
			rq.op = OP_EXCLUDE;
			a = longint'(int'($urandom()));
			case ($urandom_range(0, 9))
				0: begin
					// inverted range
					b = longint'(int'($urandom()));
					if (a < b) begin
						w = a;
						a = b;
						b = w;
					end
				end
				1: b = a;
				2, 3, 4: begin
					b = a + $urandom_range(0, 20);
					if (b > INT32_MAX)
						b = INT32_MAX;
				end
				default: begin
					b = longint'(int'($urandom()));
					if (a > b) begin
						w = a;
						a = b;
						b = w;
					end
				end
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					if (b >= a)
						ex = a + (longint'($urandom()) % (b - a + 1));
					else
						ex = longint'(int'($urandom()));
				end
				5: ex = a;
				6: ex = b;
				7, 8: ex = longint'(int'($urandom()));
				default: ex = ($urandom_range(0, 1) != 0) ? a - 1 : b + 1;
			endcase
			rq.excluded = ex[31:0];
			rq.low_bound = bound_bits(a);
			rq.high_bound = bound_bits(b);
		end
		return rq;
	endfunction

	task automatic queue_request(input logic op, input logic [63:0] lo, input logic [63:0] hi,
			input logic [31:0] ex);
		range_request_t rq;
		rq.op = op;
		rq.low_bound = lo;
		rq.high_bound = hi;
		rq.excluded = ex;
		request_queue.push_back(rq);
	endtask

	// Write the seed register while the block is idle; the predictor drops
	// its seeded state just like the block does.
	task automatic write_seed(input logic [63:0] seed);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= seed;
		seed_reg = seed;
		seeded = 1'b0;
		n_seeds++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Hold the sender until every request went out and every result came back,
	// then let the block settle. Sample on the falling edge so the check never
	// races the clocked processes.
	task automatic wait_idle();
		while (request_queue.size() != 0 || s_tvalid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Request driver: pops pending requests, predicts on acceptance
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(predict_range_draw(cur_req));
				if (cur_req.op == OP_PLAIN)
					n_plain++;
				else
					n_exclude++;
			end
			// Advance only when the bus is free or the current transaction just
			// went through; otherwise hold the offered request steady.
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					cur_req = request_queue.pop_front();
					s_tdata <= {cur_req.excluded, cur_req.high_bound, cur_req.low_bound};
					s_tuser <= cur_req.op;
					s_tvalid <= 1'b1;
					tx_gap <= pick_gap(tx_pace);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side back-pressure. A long hold-off, when asked for, keeps
	// m_tready low long enough for the block to fill its output register,
	// finish the next request and stall its input.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : receiver
		int gap;
		if (arst_n) begin
			if (holds_served != holds_asked) begin
				rx_hold <= LONG_HOLD;
				holds_served <= holds_served + 1;
				m_tready <= 1'b0;
			end else if (rx_hold != 0) begin
				rx_hold <= rx_hold - 1;
				m_tready <= 1'b0;
			end else begin
				gap = pick_gap(rx_pace);
				m_tready <= (gap == 0);
				rx_hold <= (gap == 0) ? 0 : gap - 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare each transaction with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		range_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result value %h status %0d", $time, m_tdata, m_tuser);
			end else begin
				want = awaited_results.pop_front();
				if (m_tdata !== want.value) begin
					errors++;
					$display("%0t: value mismatch: expected %h, got %h",
						$time, want.value, m_tdata);
				end
				if (m_tuser !== want.status) begin
					errors++;
					$display("%0t: status mismatch: expected %0d, got %0d",
						$time, want.status, m_tuser);
				end
				if (want.status == STATUS_INVERTED)
					n_inverted++;
				if (want.status == STATUS_EMPTY)
					n_empty++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [63:0] phase_seeds [NUM_PHASES];
		phase_seeds = '{ALL_ONES, 64'd0, 64'd1, 64'h8000_0000_0000_0000,
			rand64(), rand64(), 64'h5555_5555_aaaa_aaaa};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests on the reset seed. Open with two error cases so
		// seeding must wait for the first real draw.
		queue_request(OP_EXCLUDE, 64'd5, 64'hffff_ffff_ffff_fffd, 32'd0);
		queue_request(OP_EXCLUDE, 64'd7, 64'd7, 32'd7);
		// plain range: full 64-bit span, single value, wrapping spans
		queue_request(OP_PLAIN, 64'd0, ALL_ONES, 32'd0);
		queue_request(OP_PLAIN, 64'd0, 64'd0, EX_MAX);
		queue_request(OP_PLAIN, ALL_ONES, ALL_ONES, EX_MIN);
		queue_request(OP_PLAIN, ALL_ONES, 64'd0, 32'hffff_ffff);
		queue_request(OP_PLAIN, 64'd5, 64'd3, 32'd1);
		queue_request(OP_PLAIN, 64'd0, 64'd1, 32'd0);
		queue_request(OP_PLAIN, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 32'd0);
		queue_request(OP_PLAIN, 64'd1000, 64'd1999, 32'd1500);
		// exclusion op: inverted extremes, excluded value outside on both sides
		queue_request(OP_EXCLUDE, POS_MAX32, NEG_MIN32, 32'd0);
		queue_request(OP_EXCLUDE, 64'd0, 64'd10, 32'hffff_ffff);
		queue_request(OP_EXCLUDE, 64'd0, 64'd10, 32'd11);
		// full 32-bit range with the excluded value in the middle and at the ends
		queue_request(OP_EXCLUDE, NEG_MIN32, POS_MAX32, 32'd0);
		queue_request(OP_EXCLUDE, NEG_MIN32, POS_MAX32, EX_MIN);
		queue_request(OP_EXCLUDE, NEG_MIN32, POS_MAX32, EX_MAX);
		// single value: excluded (nothing left) and not excluded
		queue_request(OP_EXCLUDE, 64'd7, 64'd7, 32'd8);
		queue_request(OP_EXCLUDE, NEG_MIN32, NEG_MIN32, EX_MIN);
		queue_request(OP_EXCLUDE, POS_MAX32, POS_MAX32, EX_MAX);
		// two values, either one excluded
		queue_request(OP_EXCLUDE, ALL_ONES, 64'd0, 32'hffff_ffff);
		queue_request(OP_EXCLUDE, ALL_ONES, 64'd0, 32'd0);
		// junk in the upper bound bits must not matter
		queue_request(OP_EXCLUDE, 64'h1234_5678_0000_0003, 64'h0000_0001_ffff_fffe, 32'd0);
		queue_request(OP_EXCLUDE, 64'hdead_beef_ffff_fff0, 64'h0000_0001_0000_0010, 32'd0);
		queue_request(OP_PLAIN, 64'hdead_beef_ffff_fff0, 64'h0000_0001_0000_0010, 32'd0);
		wait_idle();

		// Random phases, each on its own seed and pacing
		for (int p = 0; p < NUM_PHASES; p++) begin
			// back-to-back writes once: only the last seed may count
			if (p == 1)
				write_seed(rand64());
			write_seed(phase_seeds[p]);
			case (p)
				0: begin
					tx_pace = PACE_FULL;
					rx_pace = PACE_FULL;
				end
				3: begin
					tx_pace = PACE_FULL;
					rx_pace = PACE_RANDOM;
				end
				4: begin
					tx_pace = PACE_RANDOM;
					rx_pace = PACE_FULL;
				end
				default: begin
					tx_pace = PACE_RANDOM;
					rx_pace = PACE_RANDOM;
				end
			endcase
			// long result-side stall while requests keep coming
			if (p == 2)
				holds_asked++;
			for (int i = 0; i < PHASE_ITEMS; i++)
				request_queue.push_back(random_request());
			wait_idle();
		end

		$display("Covered %0d requests (%0d plain range, %0d with exclusion) over %0d seed writes",
			n_plain + n_exclude, n_plain, n_exclude, n_seeds);
		$display("Error results seen: %0d inverted range, %0d nothing eligible; %0d mismatches",
			n_inverted, n_empty, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard limit on the whole run, far above the slowest correct one
	initial begin
		#20_000_000;
		$display("%0t: timeout with %0d requests pending and %0d results awaited",
			$time, request_queue.size(), awaited_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
rtl/xrrg_pkg.sv
rtl/xrrg_ctrl.sv
rtl/xrrg_datapath.sv
rtl/xoshiro_range_random_generator.sv
bench/xoshiro_range_random_generator_tb.sv
